FILE: rtl/tablet_report_serializer_macros.svh
// Assertion macros shared by the checker of the tablet report serializer.
// Holds macro definitions only; no other file is needed to use it.
`ifndef TABLET_REPORT_SERIALIZER_MACROS_SVH
`define TABLET_REPORT_SERIALIZER_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define TRS_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tablet report serializer check failed");

// Next-cycle implication, switched off while reset is held.
`define TRS_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tablet report serializer check failed");

// Next-cycle implication that is also checked across reset.
`define TRS_ASSERT_ALWAYS(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("tablet report serializer check failed");

`endif

FILE: rtl/trs_pkg.sv
// Package of the tablet report serializer: screen geometry, scaling constants,
// event and command codes, protocol bytes and the job type. Depends on nothing.
package trs_pkg;

    localparam int SCREEN_W = 1024;
    localparam int SCREEN_H = 768;
    localparam int TABLET_SPAN = 2200;

    localparam int TAB_W = 12;
    localparam int COORD_W = 12;
    localparam int SCREEN_BIG = (SCREEN_W > SCREEN_H) ? SCREEN_W : SCREEN_H;
    localparam int PROD_W = $clog2((SCREEN_BIG - 1) * TABLET_SPAN + 1);
    localparam int DIV_SHIFT = PROD_W + TAB_W;
    localparam int MUL_W = DIV_SHIFT + TAB_W;

    localparam logic [COORD_W-1:0] X_MAX = COORD_W'(SCREEN_W - 1);
    localparam logic [COORD_W-1:0] Y_MAX = COORD_W'(SCREEN_H - 1);
    localparam logic [PROD_W-1:0]  SPAN_P = PROD_W'(TABLET_SPAN);
    localparam logic [PROD_W-1:0]  DIV_X_P = PROD_W'(SCREEN_W);
    localparam logic [PROD_W-1:0]  DIV_Y_P = PROD_W'(SCREEN_H);
    localparam logic [63:0] RECIP_X = (64'd1 << DIV_SHIFT) / SCREEN_W;
    localparam logic [63:0] RECIP_Y = (64'd1 << DIV_SHIFT) / SCREEN_H;
    localparam logic [MUL_W-1:0] RECIP_X_M = MUL_W'(RECIP_X);
    localparam logic [MUL_W-1:0] RECIP_Y_M = MUL_W'(RECIP_Y);

    // Event kinds on the cmd field.
    localparam logic [1:0] CMD_HOST = 2'd0;
    localparam logic [1:0] CMD_MOVE = 2'd1;
    localparam logic [1:0] CMD_BTN  = 2'd2;

    // Host command bytes.
    localparam logic [7:0] HB_POLL = 8'h50;
    localparam logic [7:0] HB_REQ  = 8'h44;
    localparam logic [7:0] HB_AUTO = 8'h52;
    localparam logic [7:0] HB_TEST = 8'h54;

    // Button codes and the flag each one drives.
    localparam logic [1:0] BTN_LEFT  = 2'd0;
    localparam logic [1:0] BTN_RIGHT = 2'd2;
    localparam logic [2:0] FLAG_LEFT  = 3'b010;
    localparam logic [2:0] FLAG_RIGHT = 3'b100;

    // Protocol bytes.
    localparam logic [7:0] HDR_BASE = 8'hC0;
    localparam logic [7:0] TEST_B0 = 8'hA0;
    localparam logic [7:0] TEST_B1 = 8'h04;
    localparam logic [7:0] TEST_B2 = 8'h11;
    localparam logic [7:0] TEST_B3 = 8'h00;
    localparam logic [7:0] REPORT_SPACE = 8'd5;

    localparam int IDX_W = 3;
    localparam logic [IDX_W-1:0] IDX_HDR    = 3'd0;
    localparam logic [IDX_W-1:0] IDX_X_LO   = 3'd1;
    localparam logic [IDX_W-1:0] IDX_X_HI   = 3'd2;
    localparam logic [IDX_W-1:0] IDX_Y_LO   = 3'd3;
    localparam logic [IDX_W-1:0] IDX_Y_HI   = 3'd4;
    localparam logic [IDX_W-1:0] REPORT_END = IDX_Y_HI;
    localparam logic [IDX_W-1:0] TEST_END   = IDX_Y_LO;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_POLL,
        OP_REQ,
        OP_AUTO,
        OP_TEST,
        OP_MOVE,
        OP_BTN
    } t_op;

    typedef struct packed {
        logic             is_test;
        logic [7:0]       header;
        logic [TAB_W-1:0] tab_x;
        logic [TAB_W-1:0] tab_y;
    } t_job;

endpackage

FILE: rtl/trs_front.sv
// Front part of the tablet report serializer: decodes events, scales moves,
// keeps the tablet state and hands jobs to the queue. Uses trs_pkg.
module trs_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_cmd,
    input  logic [7:0]                i_host_byte,
    input  logic [trs_pkg::COORD_W-1:0] i_pos_x,
    input  logic [trs_pkg::COORD_W-1:0] i_pos_y,
    input  logic [1:0]                i_button,
    input  logic                      i_pressed,
    input  logic [7:0]                i_tx_space,
    output logic                      o_push,
    output trs_pkg::t_job             o_job,
    input  logic                      i_full
);
    import trs_pkg::*;

    // Stage 0: decoded event and scaled-up coordinates.
    logic              r_s0_valid;
    t_op               r_s0_op;
    logic [2:0]        r_s0_mask;
    logic              r_s0_pressed;
    logic              r_s0_room;
    logic [PROD_W-1:0] r_s0_px;
    logic [PROD_W-1:0] r_s0_py;

    // Stage 1: quotient estimates, committed from here.
    logic              r_s1_valid;
    t_op               r_s1_op;
    logic [2:0]        r_s1_mask;
    logic              r_s1_pressed;
    logic              r_s1_room;
    logic [PROD_W-1:0] r_s1_px;
    logic [PROD_W-1:0] r_s1_py;
    logic [TAB_W-1:0]  r_s1_qx;
    logic [TAB_W-1:0]  r_s1_qy;

    // Architectural state.
    logic              r_auto;
    logic [2:0]        r_buttons;
    logic [TAB_W-1:0]  r_tab_x;
    logic [TAB_W-1:0]  r_tab_y;

    logic              n_auto;
    logic [2:0]        n_buttons;
    logic [TAB_W-1:0]  n_tab_x;
    logic [TAB_W-1:0]  n_tab_y;

    t_op               dec_op;
    logic [2:0]        dec_mask;
    logic [COORD_W-1:0] px_c;
    logic [COORD_W-1:0] py_c;
    logic [COORD_W-1:0] py_f;
    logic [MUL_W-1:0]  mul_x;
    logic [MUL_W-1:0]  mul_y;
    logic [PROD_W-1:0] rem_x;
    logic [PROD_W-1:0] rem_y;
    logic              emit;
    logic              commit;
    logic              s1_free;
    logic              s0_move;
    logic              accept;

    assign commit  = r_s1_valid && (!emit || !i_full);
    assign s1_free = !r_s1_valid || commit;
    assign s0_move = r_s0_valid && s1_free;
    assign o_ready = !r_s0_valid || s1_free;
    assign accept  = i_valid && o_ready;

    always_comb begin
        dec_op = OP_NONE;
        unique case (i_cmd)
            CMD_HOST: begin
                unique case (i_host_byte)
                    HB_POLL: dec_op = OP_POLL;
                    HB_REQ:  dec_op = OP_REQ;
                    HB_AUTO: dec_op = OP_AUTO;
                    HB_TEST: dec_op = OP_TEST;
                    default: dec_op = OP_NONE;
                endcase
            end
            CMD_MOVE: dec_op = OP_MOVE;
            CMD_BTN:  dec_op = OP_BTN;
            default:  dec_op = OP_NONE;
        endcase
    end

    always_comb begin
        unique case (i_button)
            BTN_LEFT:  dec_mask = FLAG_LEFT;
            BTN_RIGHT: dec_mask = FLAG_RIGHT;
            default:   dec_mask = 3'b000;
        endcase
    end

    assign px_c = (i_pos_x > X_MAX) ? X_MAX : i_pos_x;
    assign py_c = (i_pos_y > Y_MAX) ? Y_MAX : i_pos_y;
    assign py_f = Y_MAX - py_c;

    // Division by the screen size as a reciprocal multiply; the estimate
    // is at most one below the true quotient and is corrected at commit.
    assign mul_x = MUL_W'(r_s0_px) * RECIP_X_M;
    assign mul_y = MUL_W'(r_s0_py) * RECIP_Y_M;

    assign rem_x = r_s1_px - PROD_W'(r_s1_qx) * DIV_X_P;
    assign rem_y = r_s1_py - PROD_W'(r_s1_qy) * DIV_Y_P;

    always_comb begin
        n_auto    = r_auto;
        n_buttons = r_buttons;
        n_tab_x   = r_tab_x;
        n_tab_y   = r_tab_y;
        emit      = 1'b0;
        unique case (r_s1_op) inside
            OP_POLL: begin
                emit   = r_s1_room;
                n_auto = 1'b0;
            end
            OP_REQ:  n_auto = 1'b0;
            OP_AUTO: n_auto = 1'b1;
            OP_TEST: emit = 1'b1;
            OP_MOVE: begin
                n_tab_x = r_s1_qx + TAB_W'(rem_x >= DIV_X_P);
                n_tab_y = r_s1_qy + TAB_W'(rem_y >= DIV_Y_P);
                emit    = r_auto && r_s1_room;
            end
            OP_BTN: begin
                n_buttons = r_s1_pressed ? (r_buttons | r_s1_mask)
                                         : (r_buttons & ~r_s1_mask);
                emit      = r_auto && r_s1_room;
            end
            default: emit = 1'b0;
        endcase
    end

    assign o_push        = r_s1_valid && emit && !i_full;
    assign o_job.is_test = (r_s1_op == OP_TEST);
    assign o_job.header  = HDR_BASE + {5'b00000, n_buttons} + 8'd1;
    assign o_job.tab_x   = n_tab_x;
    assign o_job.tab_y   = n_tab_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_auto     <= 1'b0;
            r_buttons  <= 3'b000;
            r_tab_x    <= '0;
            r_tab_y    <= '0;
        end else begin
            if (o_ready) begin
                r_s0_valid <= i_valid;
            end
            if (s1_free) begin
                r_s1_valid <= r_s0_valid;
            end
            if (commit) begin
                r_auto    <= n_auto;
                r_buttons <= n_buttons;
                r_tab_x   <= n_tab_x;
                r_tab_y   <= n_tab_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s0_op      <= dec_op;
            r_s0_mask    <= dec_mask;
            r_s0_pressed <= i_pressed;
            r_s0_room    <= (i_tx_space >= REPORT_SPACE);
            r_s0_px      <= PROD_W'(px_c) * SPAN_P;
            r_s0_py      <= PROD_W'(py_f) * SPAN_P;
        end
        if (s0_move) begin
            r_s1_op      <= r_s0_op;
            r_s1_mask    <= r_s0_mask;
            r_s1_pressed <= r_s0_pressed;
            r_s1_room    <= r_s0_room;
            r_s1_px      <= r_s0_px;
            r_s1_py      <= r_s0_py;
            r_s1_qx      <= mul_x[DIV_SHIFT +: TAB_W];
            r_s1_qy      <= mul_y[DIV_SHIFT +: TAB_W];
        end
    end

endmodule

FILE: rtl/trs_queue.sv
// Short job queue between the front and back parts of the serializer.
// Uses trs_pkg for the job type and depth.
module trs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  trs_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output trs_pkg::t_job o_job
);
    import trs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

FILE: rtl/trs_back.sv
// Back part of the serializer: turns queued jobs into bytes, one per cycle
// while the consumer is ready, behind an output register. Uses trs_pkg.
module trs_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  trs_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_tx_byte,
    output logic          o_last
);
    import trs_pkg::*;

    logic [IDX_W-1:0] r_idx;
    logic             r_valid;
    logic [7:0]       r_byte;
    logic             r_last;
    logic [7:0]       n_byte;
    logic             n_last;
    logic             load;
    logic             take;

    assign load  = !r_valid || i_ready;
    assign take  = load && !i_empty;
    assign o_pop = take && n_last;

    assign n_last = (r_idx == (i_job.is_test ? TEST_END : REPORT_END));

    always_comb begin
        n_byte = 8'h00;
        if (i_job.is_test) begin
            case (r_idx)
                IDX_HDR:  n_byte = TEST_B0;
                IDX_X_LO: n_byte = TEST_B1;
                IDX_X_HI: n_byte = TEST_B2;
                default:  n_byte = TEST_B3;
            endcase
        end else begin
            case (r_idx)
                IDX_HDR:  n_byte = i_job.header;
                IDX_X_LO: n_byte = {2'b00, i_job.tab_x[5:0]};
                IDX_X_HI: n_byte = {2'b00, i_job.tab_x[11:6]};
                IDX_Y_LO: n_byte = {2'b00, i_job.tab_y[5:0]};
                default:  n_byte = {2'b00, i_job.tab_y[11:6]};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (take) begin
                r_idx <= n_last ? '0 : r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte <= n_byte;
            r_last <= n_last;
        end
    end

    assign o_valid   = r_valid;
    assign o_tx_byte = r_byte;
    assign o_last    = r_last;

endmodule

FILE: rtl/tablet_report_serializer.sv
// Serial tablet report serializer. Each input item is one event: a host
// command byte, a pointer move or a button change. Items are taken at one
// per cycle whenever the two-entry job queue has room; an item that causes
// no bytes leaves the front after passing stage 0 and stage 1. An item
// that causes a report yields five bytes (a self-test reply four), which
// the byte serializer sends one per cycle while the consumer is ready, so
// with every item reporting the serializer sets the sustained rate. Moves
// are scaled to the tablet range 0..2197 by a reciprocal multiply in the
// front pipeline, with a correction step at the stage where the tablet
// state is updated.
// Depends on trs_pkg, trs_front, trs_queue and trs_back.
module tablet_report_serializer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_cmd,
    input  logic [7:0]                  i_host_byte,
    input  logic [trs_pkg::COORD_W-1:0] i_pos_x,
    input  logic [trs_pkg::COORD_W-1:0] i_pos_y,
    input  logic [1:0]                  i_button,
    input  logic                        i_pressed,
    input  logic [7:0]                  i_tx_space,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [7:0]                  o_tx_byte,
    output logic                        o_last
);
    import trs_pkg::*;

    // Jobs travel from the front to the back through the queue; each job
    // carries a snapshot of the header and coordinates taken at commit, so
    // the front may keep updating state while earlier reports are sent.
    logic push;
    logic full;
    logic pop;
    logic empty;
    t_job front_job;
    t_job back_job;

    trs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_host_byte (i_host_byte),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_button    (i_button),
        .i_pressed   (i_pressed),
        .i_tx_space  (i_tx_space),
        .o_push      (push),
        .o_job       (front_job),
        .i_full      (full)
    );

    trs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (back_job)
    );

    // The back part holds its byte in an output register and loads the next
    // byte as the consumer takes the current one.
    trs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (empty),
        .i_job     (back_job),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_tx_byte (o_tx_byte),
        .o_last    (o_last)
    );

endmodule

FILE: rtl/trs_checker.sv
// Port-level checker for the tablet report serializer, bound to the top level.
// Depends on the assertion macros header and the top level's ports.
`include "tablet_report_serializer_macros.svh"

module trs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_tx_byte,
    input logic       o_last
);
    // High while the next byte shown starts a new report or reply.
    logic r_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (o_valid && i_ready) begin
            r_first <= o_last;
        end
    end

    `TRS_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n, !o_valid)
    `TRS_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_tx_byte) && $stable(o_last))
    `TRS_ASSERT_NOW(a_first_byte, i_clk, i_rst_n, o_valid && r_first, o_tx_byte == 8'hA0 || (o_tx_byte[7:3] == 5'b11000 && o_tx_byte[0]))
    `TRS_ASSERT_NOW(a_body_byte, i_clk, i_rst_n, o_valid && !r_first, o_tx_byte[7:6] == 2'b00)

endmodule

bind tablet_report_serializer trs_checker u_trs_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_tx_byte (o_tx_byte),
    .o_last    (o_last)
);
